### rtl/hopc_pkg.sv
package hopc_pkg;

    // Widths of the item fields
    localparam int CODE_BITS   = 63;
    localparam int LEN_W       = 6;
    localparam int CHK_MAX     = 6;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 80;

    // Mode register codes
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // One result item
    typedef struct packed {
        logic [LEN_W-1:0]     syndrome;
        logic [CODE_BITS-1:0] bits;
        logic [LEN_W-1:0]     len;
    } result_t;

    // True for positions 1, 2, 4, 8, ...
    function automatic logic is_pow2(input int p);
        return (p != 0) && ((p & (p - 1)) == 0);
    endfunction

    // Bit j set when j < len (positions inside the word)
    function automatic logic [CODE_BITS-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [CODE_BITS-1:0] m;
        m = '0;
        for (int j = 0; j < CODE_BITS; j++)
        begin
            m[j] = (LEN_W'(j) < len);
        end
        return m;
    endfunction

    // Positions whose number has bit i set
    function automatic logic [CODE_BITS-1:0] grp_mask(input int i);
        logic [CODE_BITS-1:0] m;
        m = '0;
        for (int p = 1; p <= CODE_BITS; p++)
        begin
            m[p-1] = ((p >> i) & 1) != 0;
        end
        return m;
    endfunction

    // Data bits in order onto the non-power-of-two positions
    function automatic logic [CODE_BITS-1:0] spread(input logic [CODE_BITS-1:0] data);
        logic [CODE_BITS-1:0] code;
        int d;
        code = '0;
        d = 0;
        for (int p = 1; p <= CODE_BITS; p++)
        begin
            if (!is_pow2(p))
            begin
                code[p-1] = data[d];
                d++;
            end
        end
        return code;
    endfunction

    // Non-power-of-two positions back to packed data bits
    function automatic logic [CODE_BITS-1:0] gather(input logic [CODE_BITS-1:0] code);
        logic [CODE_BITS-1:0] data;
        int d;
        data = '0;
        d = 0;
        for (int p = 3; p <= CODE_BITS; p++)
        begin
            if (!is_pow2(p))
            begin
                data[d] = code[p-1];
                d++;
            end
        end
        return data;
    endfunction

endpackage

### rtl/hopc_encoder.sv
module hopc_encoder
    import hopc_pkg::*;
(
    input  logic [LEN_W-1:0]     n,
    input  logic [CODE_BITS-1:0] data,
    output result_t              res
);

    logic [2:0]           k;
    logic [LEN_W:0]       total;
    logic [CODE_BITS-1:0] sp;
    logic [CODE_BITS-1:0] code;

    // Fewest check bits covering n data bits
    always_comb
    begin
        if (n == '0)
            k = 3'd0;
        else if (n <= LEN_W'(1))
            k = 3'd2;
        else if (n <= LEN_W'(4))
            k = 3'd3;
        else if (n <= LEN_W'(11))
            k = 3'd4;
        else if (n <= LEN_W'(26))
            k = 3'd5;
        else if (n <= LEN_W'(57))
            k = 3'd6;
        else
            k = 3'd7;
    end

    assign total = {1'b0, n} + (LEN_W+1)'(k);
    assign sp    = spread(data & len_mask(n));

    // Odd-parity check bits for the groups in use
    always_comb
    begin
        code = sp;
        for (int i = 0; i < CHK_MAX; i++)
        begin
            if (3'(i) < k)
                code[(1 << i) - 1] = ~^(sp & grp_mask(i));
        end
    end

    // Words longer than the maximum give an all-zero item
    always_comb
    begin
        res.syndrome = '0;
        if (total > (LEN_W+1)'(CODE_BITS))
        begin
            res.len  = '0;
            res.bits = '0;
        end
        else
        begin
            res.len  = total[LEN_W-1:0];
            res.bits = code;
        end
    end

endmodule

### rtl/hopc_decoder.sv
module hopc_decoder
    import hopc_pkg::*;
(
    input  logic [LEN_W-1:0]     len,
    input  logic [CODE_BITS-1:0] code,
    output result_t              res
);

    logic [CODE_BITS-1:0] w;
    logic [CODE_BITS-1:0] flip;
    logic [LEN_W-1:0]     syn;
    logic [2:0]           nchk;

    assign w = code & len_mask(len);

    // A group inside the word fails when its full parity is even
    always_comb
    begin
        for (int i = 0; i < CHK_MAX; i++)
        begin
            syn[i] = (LEN_W'(1 << i) <= len) && !(^(w & grp_mask(i)));
        end
    end

    // Correct one bit when the syndrome points inside the word
    assign flip = ((syn != '0) && (syn <= len)) ?
                  (CODE_BITS'(1) << (syn - LEN_W'(1))) : '0;

    // Check positions at or below len
    always_comb
    begin
        if (len >= LEN_W'(32))
            nchk = 3'd6;
        else if (len >= LEN_W'(16))
            nchk = 3'd5;
        else if (len >= LEN_W'(8))
            nchk = 3'd4;
        else if (len >= LEN_W'(4))
            nchk = 3'd3;
        else if (len >= LEN_W'(2))
            nchk = 3'd2;
        else if (len >= LEN_W'(1))
            nchk = 3'd1;
        else
            nchk = 3'd0;
    end

    assign res.len      = len - LEN_W'(nchk);
    assign res.bits     = gather(w ^ flip);
    assign res.syndrome = syn;

endmodule

### rtl/hamming_odd_parity_codec.sv
// Hamming single-error-correcting codec with odd parity over words of up to
// 63 bits. With codec_mode 0 an item's data (up to 57 bits) comes back as a
// codeword; with codec_mode 1 a codeword is checked, one bit corrected and the
// data returned with the syndrome. One item is accepted every clock cycle while
// results are taken; each result passes through the input register and the
// result register around the parity trees before it is valid on the output.
// A result held back by m_axis_tready stalls the input only once both registers
// are full. Write codec_mode only while no items are in flight.
module hamming_odd_parity_codec
    import hopc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // in_length[5:0], in_bits[68:6]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // out_length[5:0], out_bits[68:6],
                                                  // syndrome[74:69]
);

    logic                 codec_mode_reg;
    logic                 s1_valid_reg;
    logic [LEN_W-1:0]     s1_len_reg;
    logic [CODE_BITS-1:0] s1_bits_reg;
    logic                 out_valid_reg;
    result_t              out_reg;
    result_t              res_next;
    result_t              enc_res;
    result_t              dec_res;
    logic                 adv;
    logic                 s_accept;

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            codec_mode_reg <= MODE_ENCODE;
        else if (cfg_we)
            codec_mode_reg <= cfg_wdata;
    end

    // Pipeline moves whenever the result slot is free or being taken
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || adv;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                s1_valid_reg <= s_axis_tvalid;
            if (adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_len_reg  <= s_axis_tdata[LEN_W-1:0];
            s1_bits_reg <= s_axis_tdata[LEN_W+CODE_BITS-1:LEN_W];
        end
    end

    hopc_encoder u_enc (
        .n    (s1_len_reg),
        .data (s1_bits_reg),
        .res  (enc_res)
    );

    hopc_decoder u_dec (
        .len  (s1_len_reg),
        .code (s1_bits_reg),
        .res  (dec_res)
    );

    assign res_next = (codec_mode_reg == MODE_DECODE) ? dec_res : enc_res;

    // Result register
    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
            out_reg <= res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W-2*LEN_W-CODE_BITS)'(0),
                            out_reg.syndrome, out_reg.bits, out_reg.len};

    // Encoded items never carry a syndrome
    a_enc_no_syn: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s1_valid_reg && codec_mode_reg == MODE_ENCODE) |=> (out_reg.syndrome == '0))
        else $error("encode result with nonzero syndrome");

    // Bits beyond the reported length are zero
    a_bits_in_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((out_reg.bits & ~len_mask(out_reg.len)) == '0))
        else $error("result bits beyond out_length");

    // A stalled item in the input register is not dropped
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !adv) |=>
            (s1_valid_reg && $stable(s1_len_reg) && $stable(s1_bits_reg)))
        else $error("input register lost a stalled item");

    // An item moving forward fills the result slot
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s1_valid_reg) |=> out_valid_reg)
        else $error("item lost between stages");

endmodule

### tb/tb_hamming_odd_parity_codec.sv
`timescale 1ns / 100ps

module tb_hamming_odd_parity_codec;
    import hopc_pkg::*;

    // One input item: word length and bits
    typedef struct packed {
        logic [LEN_W-1:0]     length;
        logic [CODE_BITS-1:0] word;
    } code_item_t;

    // One result item as the codec should return it
    typedef struct packed {
        logic [LEN_W-1:0]     length;
        logic [CODE_BITS-1:0] word;
        logic [LEN_W-1:0]     syn;
    } codec_out_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic                   cfg_wdata = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;  // in_length[5:0], in_bits[68:6]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;       // out_length[5:0], out_bits[68:6],
                                                // syndrome[74:69]

    code_item_t pending_words[$];
    codec_out_t expected_words[$];
    logic       mode_shadow = MODE_ENCODE;
    logic       word_taken = 1'b0;
    int         idle_pct = 24;
    int         mismatches = 0;

    hamming_odd_parity_codec uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Positions 1, 2, 4, 8, ... carry check bits
    function automatic logic is_check_position(input int p);
        return (p != 0) && ((p & (p - 1)) == 0);
    endfunction

    // Ones below bit n
    function automatic logic [CODE_BITS-1:0] low_bits(input int n);
        if (n >= CODE_BITS)
            return {CODE_BITS{1'b1}};
        return (CODE_BITS'(1) << n) - CODE_BITS'(1);
    endfunction

    // Parity of the data positions covered by check position cp, up to len
    function automatic logic group_odd(input logic [CODE_BITS-1:0] w, input int cp,
                                       input int len);
        logic par;
        par = 1'b0;
        for (int p = cp + 1; p <= len; p++)
        begin
            if ((p & cp) != 0 && !is_check_position(p))
                par ^= w[p-1];
        end
        return par;
    endfunction

    // Expected result for one item in the given mode
    function automatic codec_out_t hamming_predict(input logic mode,
                                                   input logic [LEN_W-1:0] len_in,
                                                   input logic [CODE_BITS-1:0] bits_in);
        codec_out_t           r;
        logic [CODE_BITS-1:0] w;
        int                   n;
        int                   k;
        int                   clen;
        int                   d;
        int                   cp;
        int                   syn;
        r = '0;
        n = int'(len_in);
        w = bits_in & low_bits(n);
        if (mode == MODE_ENCODE)
        begin
            k = 0;
            while ((1 << k) - k < n + 1)
                k++;
            clen = n + k;
            // too long for the word: all fields stay zero
            if (clen <= CODE_BITS)
            begin
                d = 0;
                for (int p = 1; p <= clen; p++)
                begin
                    if (!is_check_position(p))
                    begin
                        r.word[p-1] = w[d];
                        d++;
                    end
                end
                for (int i = 0; i < k; i++)
                begin
                    cp = 1 << i;
                    if (!group_odd(r.word, cp, clen))
                        r.word[cp-1] = 1'b1;
                end
                r.length = LEN_W'(clen);
            end
        end
        else
        begin
            clen = n;
            syn = 0;
            for (cp = 1; cp <= clen; cp = cp << 1)
            begin
                if ((group_odd(w, cp, clen) ? 1'b0 : 1'b1) != w[cp-1])
                    syn |= cp;
            end
            // a syndrome past the word end flips nothing
            if (syn != 0 && syn <= clen)
                w[syn-1] = ~w[syn-1];
            d = 0;
            for (int p = 3; p <= clen; p++)
            begin
                if (!is_check_position(p))
                begin
                    r.word[d] = w[p-1];
                    d++;
                end
            end
            r.length = LEN_W'(d);
            r.syn = LEN_W'(syn);
        end
        return r;
    endfunction

    function automatic logic [CODE_BITS-1:0] rand_word();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[CODE_BITS-1:0];
    endfunction

    // Mostly codable lengths, some overflow, a few empty
    function automatic int rand_encode_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 57);
        if (r < 96)
            return $urandom_range(58, 63);
        return 0;
    endfunction

    task automatic add_word(input int len, input logic [CODE_BITS-1:0] w);
        code_item_t it;
        it.length = LEN_W'(len);
        it.word = w;
        pending_words.insert(pending_words.size(), it);
    endtask

    // Valid codeword of n data bits, with fixed and random flips and, at random, junk above it
    task automatic add_codeword(input int n, input int nflips,
                                input logic [CODE_BITS-1:0] fixed);
        codec_out_t           cw;
        logic [CODE_BITS-1:0] flips;
        logic [CODE_BITS-1:0] junk;
        cw = hamming_predict(MODE_ENCODE, LEN_W'(n), rand_word());
        flips = fixed;
        for (int i = 0; i < nflips; i++)
            flips[$urandom_range(0, int'(cw.length) - 1)] ^= 1'b1;
        flips &= low_bits(int'(cw.length));
        junk = $urandom_range(0, 1) ? (rand_word() & ~low_bits(int'(cw.length))) : '0;
        add_word(int'(cw.length), (cw.word ^ flips) | junk);
    endtask

    task automatic add_decode_random();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            add_codeword($urandom_range(1, 57), 0, '0);
        else if (r < 70)
            add_codeword($urandom_range(1, 57), 1, '0);
        else if (r < 80)
            add_codeword($urandom_range(1, 57), 2, '0);
        else
            add_word($urandom_range(0, 63), rand_word());
    endtask

    task automatic write_mode(input logic v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until the codec is empty
    task automatic wait_idle();
        @(posedge clk);
        while (pending_words.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Input driver: new item only once the previous one was taken
    always @(negedge clk)
    begin
        code_item_t next_item;
        logic       next_valid;
        if (rst_n)
        begin
            if (!s_axis_tvalid || word_taken)
            begin
                next_valid = 1'b0;
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    next_item = pending_words.pop_front();
                    next_valid = 1'b1;
                    s_axis_tdata <= IN_TDATA_W'({next_item.word, next_item.length});
                end
                s_axis_tvalid <= next_valid;
            end
            m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // Monitor: check results, then record expectations for taken items
    always @(posedge clk)
    begin
        codec_out_t got;
        codec_out_t want;
        if (!rst_n)
        begin
            mode_shadow <= MODE_ENCODE;
            word_taken <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mode_shadow <= cfg_wdata;
            word_taken <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.length = m_axis_tdata[5:0];
                got.word = m_axis_tdata[68:6];
                got.syn = m_axis_tdata[74:69];
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: len %0d bits %h syn %0d",
                                 got.length, got.word, got.syn);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got.length !== want.length || got.word !== want.word ||
                        got.syn !== want.syn)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $write("mismatch: expected len %0d bits %h syn %0d,",
                                   want.length, want.word, want.syn);
                            $display(" got len %0d bits %h syn %0d",
                                     got.length, got.word, got.syn);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_words.insert(expected_words.size(),
                                      hamming_predict(mode_shadow, s_axis_tdata[5:0],
                                                      s_axis_tdata[68:6]));
        end
    end

    // Run limit
    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    // Sequence of phases
    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        write_mode(MODE_ENCODE);

        // directed encode: empty, tiny, full width, overflow, ignored high bits
        add_word(0, rand_word());
        add_word(1, '0);
        add_word(1, {CODE_BITS{1'b1}});
        add_word(2, CODE_BITS'(2));
        add_word(4, CODE_BITS'(15));
        add_word(11, CODE_BITS'(11'h555));
        add_word(26, rand_word());
        add_word(57, '0);
        add_word(57, {CODE_BITS{1'b1}});
        add_word(58, rand_word());
        add_word(63, {CODE_BITS{1'b1}});
        add_word(63, '0);
        wait_idle();
        write_mode(MODE_DECODE);

        // directed decode: short words, syndrome past the end, full width, flips
        add_word(0, {CODE_BITS{1'b1}});
        add_word(1, {CODE_BITS{1'b1}});
        add_word(2, {CODE_BITS{1'b1}});
        add_word(3, {CODE_BITS{1'b1}});
        add_word(5, '0);
        add_word(6, '0);
        add_word(63, '0);
        add_word(63, {CODE_BITS{1'b1}});
        add_codeword(57, 0, '0);
        add_codeword(57, 0, CODE_BITS'(1));
        add_codeword(57, 0, CODE_BITS'(1) << 62);
        add_codeword(4, 1, '0);
        add_codeword(26, 2, '0);
        wait_idle();
        write_mode(MODE_ENCODE);

        // random encode
        for (int i = 0; i < 300; i++)
            add_word(rand_encode_len(), rand_word());
        wait_idle();
        write_mode(MODE_DECODE);

        // random decode, mostly codewords with 0..2 errors
        for (int i = 0; i < 450; i++)
            add_decode_random();
        wait_idle();
        write_mode(MODE_ENCODE);

        // back-to-back stretch with no idling on either side
        idle_pct = 0;
        for (int i = 0; i < 250; i++)
            add_word(rand_encode_len(), rand_word());
        wait_idle();
        idle_pct = 24;
        write_mode(MODE_DECODE);

        // decode again, sender holds off mid-run until the codec drains
        for (int i = 0; i < 150; i++)
            add_decode_random();
        wait_idle();
        for (int i = 0; i < 150; i++)
            add_decode_random();
        wait_idle();

        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
